### rtl/assert_macros.svh
// Assertion macros used by the cubic_spline_interpolator top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### rtl/csi_pkg.sv
// Shared constants and types of the cubic spline interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csi_pkg;
    localparam int MaxPoints = 64;
    localparam int TimeW = 16;
    localparam int ValW = 16;
    localparam int WideW = 128;
    localparam logic ActWrite = 1'b0;
    localparam logic ActQuery = 1'b1;
    localparam int RegPointCount = 0;
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

### rtl/csi_div.sv
// Restoring divider: 128-bit magnitude by 128-bit divisor, one bit a cycle,
// with round-half-up of the quotient. Depends on csi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csi_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [csi_pkg::WideW-1:0]     i_num,
    input  wire logic [csi_pkg::WideW-1:0]     i_den,
    output csi_pkg::t_div_ctl                  o_ctl,
    output logic      [csi_pkg::WideW-1:0]     o_quo
);
    logic [csi_pkg::WideW-1:0] r_num, r_den, r_rem, r_quo;
    logic [7:0] r_cnt;
    logic r_busy, r_done;
    logic [csi_pkg::WideW:0] n_sh;
    logic [csi_pkg::WideW:0] n_diff;

    always_comb begin
        n_sh = {r_rem, r_num[csi_pkg::WideW-1]};
        n_diff = n_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 8'(csi_pkg::WideW);
            end else if (r_busy) begin
                if (r_cnt == 8'd0) begin
                    // round: 2r >= d
                    if ({r_rem, 1'b0} >= {1'b0, r_den}) r_quo <= r_quo + 1'b1;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_num <= r_num << 1;
                    if (!n_diff[csi_pkg::WideW]) begin
                        r_rem <= n_diff[csi_pkg::WideW-1:0];
                        r_quo <= {r_quo[csi_pkg::WideW-2:0], 1'b1};
                    end else begin
                        r_rem <= n_sh[csi_pkg::WideW-1:0];
                        r_quo <= {r_quo[csi_pkg::WideW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 8'd1;
                end
            end
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quo = r_quo;
endmodule
`default_nettype wire

### rtl/cubic_spline_interpolator.sv
// Cubic spline interpolator top level: knot memories, segment scan, limb multiplier,
// divider hookup and result strobe. Depends on csi_pkg, csi_div, assert_macros.svh.
// A write item stores the knot and strobes; a query scans the knots (skipped above the last
// knot), then runs a chain of limb multiplies and the divide, while a zero-width segment
// skips the multiplies and the divide. One item at a time; results
// strobe for one cycle, the receiver cannot stall. Reset: point_count back to 2.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cubic_spline_interpolator #(
    parameter int MAX_POINTS = csi_pkg::MaxPoints
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_action,
    input  wire logic [5:0]          i_knot_index,
    input  wire logic [15:0]         i_knot_time,
    input  wire logic signed [15:0]  i_knot_value,
    input  wire logic [15:0]         i_query_time,
    output logic                     o_strobe,
    output logic signed [31:0]       o_value,
    output logic [5:0]               o_segment,
    output logic                     o_saturated
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int W = csi_pkg::WideW;

    typedef enum logic [4:0] {
        S_IDLE, S_WDONE, S_LAST, S_LASTW, S_SCAN, S_SCANW, S_SEL,
        S_RD, S_RDW, S_SETUP, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_M9, S_M10, S_M11, S_DIV, S_DIVW, S_OUT
    } t_state;

    logic [15:0] r_tmem [MAX_POINTS];
    logic [15:0] r_vmem [MAX_POINTS];
    logic [AW-1:0] r_raddr;
    logic [15:0] r_trd, r_vrd;
    logic [CW-1:0] r_n;
    t_state r_st;
    logic [CW-1:0] r_i;
    logic [15:0] r_q, r_tprev;
    logic [AW-1:0] r_seg;
    logic r_found;
    logic [2:0] r_k;
    // knot window seg-1..seg+2 (times/values)
    logic signed [17:0] r_tw [4];
    logic signed [17:0] r_vw [4];
    logic signed [W-1:0] r_acc, r_tmp, r_mul, r_num, r_den;
    logic signed [35:0] r_op;
    logic r_neg, r_wflag;
    logic signed [31:0] r_val;
    logic [5:0] r_osg;
    logic r_sat, r_strobe;
    logic signed [18:0] r_s, r_h, r_e, r_dd0, r_dd1, r_dn0, r_dn1;
    logic signed [W-1:0] r_pacc;
    logic [2:0] r_mph;
    logic signed [W-1:0] n_prod;
    logic [31:0] n_limb;
    logic signed [68:0] n_lprod;
    logic signed [W-1:0] n_part;
    logic n_mwait;
    logic div_start;
    csi_pkg::t_div_ctl div_ctl;
    logic [W-1:0] div_quo;
    logic [W-1:0] n_mag;
    logic [AW:0] n_rd_idx;

    // one 32-bit limb of the wide value times the 36-bit operand per cycle
    always_comb begin
        case (r_mph[1:0])
            2'd0: n_limb = r_mul[31:0];
            2'd1: n_limb = r_mul[63:32];
            2'd2: n_limb = r_mul[95:64];
            default: n_limb = r_mul[127:96];
        endcase
        n_lprod = 69'($signed({1'b0, n_limb})) * 69'(r_op);
        n_part = W'(n_lprod) << {r_mph[1:0], 5'd0};
        n_prod = r_pacc;
        n_mwait = (r_st >= S_M3) && (r_st <= S_M11) && (r_mph != 3'd4);
    end

    assign pready = 1'b1;
    assign prdata = {{(32-CW){1'b0}}, r_n};
    assign busy = (r_st != S_IDLE);
    assign n_mag = r_num[W-1] ? -r_num : r_num;

    csi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(n_mag), .i_den(r_den), .o_ctl(div_ctl), .o_quo(div_quo)
    );
    assign div_start = (r_st == S_DIV);

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_action == csi_pkg::ActWrite
            && {1'b0, i_knot_index} < (CW+1)'(MAX_POINTS)) begin
            r_tmem[AW'(i_knot_index)] <= i_knot_time;
            r_vmem[AW'(i_knot_index)] <= i_knot_value;
        end
        r_trd <= r_tmem[r_raddr];
        r_vrd <= r_vmem[r_raddr];
    end

    // window slot k holds knot seg-1+k, clamped to 0..n-1
    always_comb begin
        n_rd_idx = (AW+1)'(r_seg) + (AW+1)'(r_k) - (AW+1)'(1);
        if (r_seg == '0 && r_k == 3'd0) n_rd_idx = '0;
        if (n_rd_idx > (AW+1)'(r_n - 1'b1)) n_rd_idx = (AW+1)'(r_n - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_n <= CW'(2);
            r_strobe <= 1'b0;
            r_mph <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'(csi_pkg::RegPointCount)) begin
                if (pwdata[6:0] < 7'd2) r_n <= CW'(2);
                else if (32'(pwdata[6:0]) > 32'(MAX_POINTS)) r_n <= CW'(MAX_POINTS);
                else r_n <= CW'(pwdata[6:0]);
            end
            if (n_mwait) begin
                // accumulate limb products, hold the sequencer
                r_pacc <= (r_mph == 3'd0) ? n_part : r_pacc + n_part;
                r_mph <= r_mph + 3'd1;
            end else begin
                r_mph <= '0;
                case (r_st)
                    S_IDLE: begin
                        if (start) begin
                            if (i_action == csi_pkg::ActWrite) begin
                                r_st <= S_WDONE;
                            end else begin
                                r_q <= i_query_time;
                                r_raddr <= AW'(r_n - 1'b1);
                                r_st <= S_LAST;
                            end
                        end
                    end
                    S_WDONE: begin
                        r_val <= '0; r_osg <= '0; r_sat <= 1'b0; r_strobe <= 1'b1;
                        r_st <= S_IDLE;
                    end
                    S_LAST: r_st <= S_LASTW;
                    S_LASTW: begin
                        if (r_q > r_trd) begin
                            r_seg <= AW'(r_n - CW'(2));
                            r_st <= S_SEL;
                        end else begin
                            r_found <= 1'b0;
                            r_seg <= '0;
                            r_i <= '0;
                            r_raddr <= '0;
                            r_st <= S_SCAN;
                        end
                    end
                    S_SCAN: r_st <= S_SCANW;
                    S_SCANW: begin
                        // r_trd is knot r_i; r_tprev knot r_i-1
                        if (r_i != '0 && !r_found && r_q >= r_tprev && r_q <= r_trd) begin
                            r_found <= 1'b1;
                            r_seg <= AW'(r_i - 1'b1);
                        end
                        r_tprev <= r_trd;
                        if (r_i == r_n - 1'b1) begin
                            r_st <= S_SEL;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_raddr <= AW'(r_i + 1'b1);
                            r_st <= S_SCAN;
                        end
                    end
                    S_SEL: begin
                        r_k <= '0;
                        r_st <= S_RD;
                    end
                    S_RD: begin
                        r_raddr <= AW'(n_rd_idx);
                        r_st <= S_RDW;
                    end
                    S_RDW: r_st <= S_SETUP;
                    S_SETUP: begin
                        r_tw[r_k[1:0]] <= 18'($signed({2'b0, r_trd}));
                        r_vw[r_k[1:0]] <= 18'($signed(r_vrd));
                        if (r_k == 3'd3) begin
                            r_st <= S_M1;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_st <= S_RD;
                        end
                    end
                    S_M1: begin
                        r_s <= 19'($signed({3'b0, r_q})) - 19'(r_tw[1]);
                        r_h <= 19'(r_tw[2]) - 19'(r_tw[1]);
                        r_e <= 19'($signed({3'b0, r_q})) - 19'(r_tw[2]);
                        r_dd0 <= 19'(r_tw[2]) - 19'(r_tw[0]);
                        r_dn0 <= 19'(r_vw[2]) - 19'(r_vw[0]);
                        r_dd1 <= 19'(r_tw[3]) - 19'(r_tw[1]);
                        r_dn1 <= 19'(r_vw[3]) - 19'(r_vw[1]);
                        r_st <= S_M2;
                    end
                    S_M2: begin
                        r_osg <= 6'(r_seg);
                        if (r_h == '0) begin
                            r_val <= 32'(r_vw[1]); r_sat <= 1'b0;
                            r_strobe <= 1'b1; r_st <= S_IDLE;
                        end else begin
                            if (r_dd0 == '0) begin r_dd0 <= 19'sd1; r_dn0 <= '0; end
                            if (r_dd1 == '0) begin r_dd1 <= 19'sd1; r_dn1 <= '0; end
                            // C0 = s*e*e : start s*e
                            r_mul <= W'(r_s); r_op <= 36'(r_e);
                            r_st <= S_M3;
                        end
                    end
                    S_M3: begin // tmp = s*e ; next C0*dn0*dd1 path
                        r_tmp <= n_prod;
                        r_mul <= n_prod; r_op <= 36'(r_e) * 36'(r_dn0);
                        r_st <= S_M4;
                    end
                    S_M4: begin // n_prod = s e e dn0 ; times dd1
                        r_mul <= n_prod; r_op <= 36'(r_dd1);
                        r_st <= S_M5;
                    end
                    S_M5: begin // acc = C0 dn0 dd1 ; C1 = s*e*s
                        r_acc <= n_prod;
                        r_mul <= r_tmp; r_op <= 36'(r_s) * 36'(r_dn1);
                        r_st <= S_M6;
                    end
                    S_M6: begin
                        r_mul <= n_prod; r_op <= 36'(r_dd0);
                        r_st <= S_M7;
                    end
                    S_M7: begin // (C0.. + C1..)*h ; then A*f0 part
                        r_mul <= r_acc + n_prod; r_op <= 36'(r_h);
                        r_st <= S_M8;
                    end
                    S_M8: begin
                        // A = s^2(2s-3h)+h^3 ; B = h^3 - A ; sum = A(f0-f1) + h^3 f1
                        r_acc <= n_prod;
                        r_mul <= W'(38'(r_s) * 38'(r_s)); r_op <= 36'(2 * r_s - 3 * r_h);
                        r_tmp <= W'(38'(r_h) * 38'(r_h));
                        r_st <= S_M9;
                    end
                    S_M9: begin
                        r_tmp <= n_prod;
                        r_mul <= r_tmp; r_op <= 36'(r_h);
                        r_st <= S_M10;
                    end
                    S_M10: begin // n_prod = h^3 ; r_tmp = s^2(2s-3h)
                        r_den <= n_prod;
                        r_mul <= r_tmp + n_prod; r_op <= 36'(r_vw[1] - r_vw[2]);
                        r_wflag <= 1'b0;
                        r_st <= S_M11;
                    end
                    S_M11: begin
                        if (!r_wflag) begin
                            r_tmp <= n_prod;
                            r_mul <= r_den; r_op <= 36'(r_vw[2]);
                            r_wflag <= 1'b1;
                            r_k <= '0;
                        end else if (r_k == 3'd0) begin
                            // poly sum -> times dd0
                            r_mul <= r_tmp + n_prod; r_op <= 36'(r_dd0);
                            r_k <= 3'd1;
                        end else if (r_k == 3'd1) begin
                            r_mul <= n_prod; r_op <= 36'(r_dd1);
                            r_k <= 3'd2;
                        end else if (r_k == 3'd2) begin
                            r_acc <= r_acc + n_prod;
                            r_mul <= r_den; r_op <= 36'(r_dd0);
                            r_k <= 3'd3;
                        end else if (r_k == 3'd3) begin
                            r_mul <= n_prod; r_op <= 36'(r_dd1);
                            r_k <= 3'd4;
                        end else begin
                            if (n_prod[W-1]) begin
                                r_den <= -n_prod; r_num <= -r_acc;
                            end else begin
                                r_den <= n_prod; r_num <= r_acc;
                            end
                            r_st <= S_DIV;
                        end
                    end
                    S_DIV: begin
                        r_neg <= r_num[W-1];
                        r_st <= S_DIVW;
                    end
                    S_DIVW: begin
                        if (div_ctl.done) r_st <= S_OUT;
                    end
                    S_OUT: begin
                        if (div_quo[W-1:32] != '0
                            || div_quo[31:0] > (r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)) begin
                            r_sat <= 1'b1;
                            r_val <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        end else begin
                            r_sat <= 1'b0;
                            r_val <= r_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
                        end
                        r_strobe <= 1'b1;
                        r_st <= S_IDLE;
                    end
                    default: r_st <= S_IDLE;
                endcase
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_value = r_val;
    assign o_segment = r_osg;
    assign o_saturated = r_sat;

    `ASSERT_IMP(a_start_idle, i_clk, i_rst_n, div_ctl.start, r_st == S_DIV)
    `ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_st == S_IDLE || r_st == S_WDONE || r_st == S_LAST)
    `ASSERT_IMP(a_count_rng, i_clk, i_rst_n, 1'b1, r_n >= CW'(2) && 32'(r_n) <= 32'(MAX_POINTS))
endmodule
`default_nettype wire
